[rtl/draw_bb_pkg.sv]
// Shared op codes and fixed field widths for the drawing-op bounding box.
package draw_bb_pkg;

	typedef enum logic [1:0] {
		CMD_END     = 2'd0,
		CMD_SEGMENT = 2'd1,
		CMD_CIRCLE  = 2'd2,
		CMD_TEXT    = 2'd3
	} cmd_t;

	localparam int IN_BITS     = 11;
	localparam int RADIUS_BITS = 10;
	localparam int BOX_BITS    = 12;

	// Start values of the running box before saturation
	localparam int START_MIN = 999;
	localparam int START_MAX = -999;

	// Character cell of a text op
	localparam int TEXT_W = 3;
	localparam int TEXT_H = 4;

	// Box given out for a symbol that nothing widened
	localparam int EMPTY_LO = 0;
	localparam int EMPTY_HI = 4;

endpackage

[rtl/draw_op_bounding_box.sv]
// Running axis-aligned bounding box over a stream of symbol drawing ops.
//
// Accepts one op per clock cycle. Segment, circle/arc and text ops widen a
// running box held in COORD_BITS-bit signed registers, each bound saturated
// to that range; an end op gives out the box as one item and sets the running
// box back to its start values (999 and -999, saturated). A symbol that no op
// widened gives the box 0,0 to 4,4. Each op passes an input register and one
// step of add, saturate and compare logic; the box item of an end op is
// written into an output register and waits there, while ops that give no
// item keep flowing. Only an end op meeting a full, stalled output register
// holds the input side.
module draw_op_bounding_box #(
	parameter int COORD_BITS = 12
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         op_valid,
	output logic                                         op_ready,
	input  logic [1:0]                                   command,
	input  logic signed [draw_bb_pkg::IN_BITS-1:0]       x_a,
	input  logic signed [draw_bb_pkg::IN_BITS-1:0]       y_a,
	input  logic signed [draw_bb_pkg::IN_BITS-1:0]       x_b,
	input  logic signed [draw_bb_pkg::IN_BITS-1:0]       y_b,
	input  logic [draw_bb_pkg::RADIUS_BITS-1:0]          radius,
	output logic                                         box_valid,
	input  logic                                         box_ready,
	output logic signed [draw_bb_pkg::BOX_BITS-1:0]      box_left,
	output logic signed [draw_bb_pkg::BOX_BITS-1:0]      box_top,
	output logic signed [draw_bb_pkg::BOX_BITS-1:0]      box_right,
	output logic signed [draw_bb_pkg::BOX_BITS-1:0]      box_bottom
);

	// Working width: holds an input plus or minus a radius, and both the
	// state range and the output range with a spare sign bit.
	localparam int WIDE_BITS = (COORD_BITS > draw_bb_pkg::BOX_BITS) ?
		COORD_BITS : draw_bb_pkg::BOX_BITS;
	localparam int EW = WIDE_BITS + 1;

	localparam int SAT_HI_I = (2 ** (COORD_BITS - 1)) - 1;
	localparam int SAT_LO_I = -SAT_HI_I - 1;

	localparam logic signed [EW-1:0] SAT_HI_E = EW'(SAT_HI_I);
	localparam logic signed [EW-1:0] SAT_LO_E = EW'(SAT_LO_I);

	localparam int RST_MIN_I = (draw_bb_pkg::START_MIN > SAT_HI_I) ?
		SAT_HI_I : draw_bb_pkg::START_MIN;
	localparam int RST_MAX_I = (draw_bb_pkg::START_MAX < SAT_LO_I) ?
		SAT_LO_I : draw_bb_pkg::START_MAX;

	localparam logic signed [COORD_BITS-1:0] RST_MIN = COORD_BITS'(RST_MIN_I);
	localparam logic signed [COORD_BITS-1:0] RST_MAX = COORD_BITS'(RST_MAX_I);

	localparam logic signed [EW-1:0] TEXT_W_E = EW'(draw_bb_pkg::TEXT_W);
	localparam logic signed [EW-1:0] TEXT_H_E = EW'(draw_bb_pkg::TEXT_H);

	localparam logic signed [draw_bb_pkg::BOX_BITS-1:0] EMPTY_LO =
		draw_bb_pkg::BOX_BITS'(draw_bb_pkg::EMPTY_LO);
	localparam logic signed [draw_bb_pkg::BOX_BITS-1:0] EMPTY_HI =
		draw_bb_pkg::BOX_BITS'(draw_bb_pkg::EMPTY_HI);

	function automatic logic signed [COORD_BITS-1:0] sat_coord(
		input logic signed [EW-1:0] v
	);
		if (v > SAT_HI_E) begin
			sat_coord = COORD_BITS'(SAT_HI_I);
		end else if (v < SAT_LO_E) begin
			sat_coord = COORD_BITS'(SAT_LO_I);
		end else begin
			sat_coord = v[COORD_BITS-1:0];
		end
	endfunction

	function automatic logic signed [draw_bb_pkg::BOX_BITS-1:0] to_box(
		input logic signed [COORD_BITS-1:0] v
	);
		logic signed [EW-1:0] e;
		e = EW'(v);
		to_box = e[draw_bb_pkg::BOX_BITS-1:0];
	endfunction

	// Input register
	logic                                    valid_s1;
	draw_bb_pkg::cmd_t                       cmd_s1;
	logic signed [draw_bb_pkg::IN_BITS-1:0]  xa_s1, ya_s1, xb_s1, yb_s1;
	logic [draw_bb_pkg::RADIUS_BITS-1:0]     radius_s1;

	// Running box
	logic signed [COORD_BITS-1:0] min_x_q, min_y_q, max_x_q, max_y_q;

	// Result register
	logic                                           box_valid_q;
	logic signed [draw_bb_pkg::BOX_BITS-1:0]        left_q, top_q, right_q, bottom_q;

	logic advance_s1;
	logic end_s1;

	logic signed [EW-1:0] xa_e, ya_e, xb_e, yb_e, r_e;
	logic signed [EW-1:0] lo_x, lo_y, hi_x, hi_y;
	logic signed [COORD_BITS-1:0] lo_x_sat, lo_y_sat, hi_x_sat, hi_y_sat;
	logic empty;

	assign end_s1     = (cmd_s1 == draw_bb_pkg::CMD_END);
	// An end op moves on only when the result register can take its item
	assign advance_s1 = valid_s1 && (!end_s1 || !box_valid_q || box_ready);
	assign op_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (op_ready) begin
			valid_s1 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op_valid && op_ready) begin
			cmd_s1    <= draw_bb_pkg::cmd_t'(command);
			xa_s1     <= x_a;
			ya_s1     <= y_a;
			xb_s1     <= x_b;
			yb_s1     <= y_b;
			radius_s1 <= radius;
		end
	end

	assign xa_e = EW'(xa_s1);
	assign ya_e = EW'(ya_s1);
	assign xb_e = EW'(xb_s1);
	assign yb_e = EW'(yb_s1);
	assign r_e  = EW'($signed({1'b0, radius_s1}));

	// Extent of the op before saturation
	always_comb begin
		unique case (cmd_s1)
			draw_bb_pkg::CMD_SEGMENT: begin
				lo_x = (xa_e < xb_e) ? xa_e : xb_e;
				hi_x = (xa_e > xb_e) ? xa_e : xb_e;
				lo_y = (ya_e < yb_e) ? ya_e : yb_e;
				hi_y = (ya_e > yb_e) ? ya_e : yb_e;
			end
			draw_bb_pkg::CMD_CIRCLE: begin
				lo_x = xa_e - r_e;
				hi_x = xa_e + r_e;
				lo_y = ya_e - r_e;
				hi_y = ya_e + r_e;
			end
			draw_bb_pkg::CMD_TEXT: begin
				lo_x = xa_e;
				hi_x = xa_e + TEXT_W_E;
				lo_y = ya_e;
				hi_y = ya_e + TEXT_H_E;
			end
			default: begin
				lo_x = xa_e;
				hi_x = xa_e;
				lo_y = ya_e;
				hi_y = ya_e;
			end
		endcase
	end

	assign lo_x_sat = sat_coord(lo_x);
	assign hi_x_sat = sat_coord(hi_x);
	assign lo_y_sat = sat_coord(lo_y);
	assign hi_y_sat = sat_coord(hi_y);

	assign empty = (min_x_q > max_x_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= RST_MIN;
			min_y_q <= RST_MIN;
			max_x_q <= RST_MAX;
			max_y_q <= RST_MAX;
		end else if (advance_s1) begin
			if (end_s1) begin
				min_x_q <= RST_MIN;
				min_y_q <= RST_MIN;
				max_x_q <= RST_MAX;
				max_y_q <= RST_MAX;
			end else begin
				if (lo_x_sat < min_x_q) min_x_q <= lo_x_sat;
				if (lo_y_sat < min_y_q) min_y_q <= lo_y_sat;
				if (hi_x_sat > max_x_q) max_x_q <= hi_x_sat;
				if (hi_y_sat > max_y_q) max_y_q <= hi_y_sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_valid_q <= 1'b0;
		end else if (advance_s1 && end_s1) begin
			box_valid_q <= 1'b1;
		end else if (box_ready) begin
			box_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && end_s1) begin
			if (empty) begin
				left_q   <= EMPTY_LO;
				top_q    <= EMPTY_LO;
				right_q  <= EMPTY_HI;
				bottom_q <= EMPTY_HI;
			end else begin
				left_q   <= to_box(min_x_q);
				top_q    <= to_box(min_y_q);
				right_q  <= to_box(max_x_q);
				bottom_q <= to_box(max_y_q);
			end
		end
	end

	assign box_valid  = box_valid_q;
	assign box_left   = left_q;
	assign box_top    = top_q;
	assign box_right  = right_q;
	assign box_bottom = bottom_q;

endmodule
